// File: hdl/dpb_pkg.sv
`timescale 1ns / 1ps

package dpb_pkg;

    // Frame geometry
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = 13;

    // Field widths
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;
    localparam int INVF_W  = 24;
    localparam int COORD_W = 32;

    // Compare width for counters against clamped dimensions
    localparam int CMP_W  = ((CNT_W + 1) > DIM_W) ? (CNT_W + 1) : DIM_W;
    // Signed half-pixel offset from the principal point
    localparam int OFS_W  = CMP_W + 1;
    // |offset| * depth, then * inv_focal
    localparam int MAG1_W = CMP_W + DEPTH_W;
    localparam int MAG2_W = MAG1_W + INVF_W;
    // Q0.24 scale plus the half-pixel unit
    localparam int ROUND_SHIFT = INVF_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0]  CX_RESET     = DIM_W'(639);
    localparam logic [DIM_W-1:0]  CY_RESET     = DIM_W'(479);
    localparam logic [INVF_W-1:0] INVF_RESET   = INVF_W'(31957);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CENTER_X_HALF = 3'd2,
        REG_CENTER_Y_HALF = 3'd3,
        REG_INV_FOCAL_Q24 = 3'd4
    } cfg_reg_t;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic               depth_valid;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      point_valid;
        logic [RGB_W-1:0]          packed_rgb;
        logic                      frame_last;
    } out_item_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic [DEPTH_W-1:0]      depth_mm;
        logic                    depth_valid;
        logic [RGB_W-1:0]        packed_rgb;
        logic                    frame_last;
    } queue_item_t;

endpackage

// File: hdl/dpb_front.sv
`timescale 1ns / 1ps

module dpb_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  dpb_pkg::in_item_t                  in_item,
    input  logic                               cfg_write,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output dpb_pkg::queue_item_t               q_item,
    output logic [dpb_pkg::INVF_W-1:0]         inv_focal
);

    logic [dpb_pkg::DIM_W-1:0]  width_reg;
    logic [dpb_pkg::DIM_W-1:0]  height_reg;
    logic [dpb_pkg::DIM_W-1:0]  cx_reg;
    logic [dpb_pkg::DIM_W-1:0]  cy_reg;
    logic [dpb_pkg::INVF_W-1:0] invf_reg;

    logic [dpb_pkg::CNT_W-1:0] col_reg;
    logic [dpb_pkg::CNT_W-1:0] col_next;
    logic [dpb_pkg::CNT_W-1:0] row_reg;
    logic [dpb_pkg::CNT_W-1:0] row_next;

    logic [dpb_pkg::CMP_W-1:0] width_eff;
    logic [dpb_pkg::CMP_W-1:0] height_eff;
    logic                      col_last;
    logic                      row_last;
    logic                      accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dpb_pkg::WIDTH_RESET;
            height_reg <= dpb_pkg::HEIGHT_RESET;
            cx_reg     <= dpb_pkg::CX_RESET;
            cy_reg     <= dpb_pkg::CY_RESET;
            invf_reg   <= dpb_pkg::INVF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dpb_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::REG_CENTER_X_HALF: cx_reg     <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::REG_CENTER_Y_HALF: cy_reg     <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::REG_INV_FOCAL_Q24: invf_reg   <= cfg_data[dpb_pkg::INVF_W-1:0];
                default: ;
            endcase
        end
    end

    assign inv_focal = invf_reg;

    // Clamp dimensions to 1..MAX_DIM
    always_comb
    begin
        if (width_reg == '0)
            width_eff = dpb_pkg::CMP_W'(1);
        else if (dpb_pkg::CMP_W'(width_reg) > dpb_pkg::CMP_W'(dpb_pkg::MAX_DIM))
            width_eff = dpb_pkg::CMP_W'(dpb_pkg::MAX_DIM);
        else
            width_eff = dpb_pkg::CMP_W'(width_reg);

        if (height_reg == '0)
            height_eff = dpb_pkg::CMP_W'(1);
        else if (dpb_pkg::CMP_W'(height_reg) > dpb_pkg::CMP_W'(dpb_pkg::MAX_DIM))
            height_eff = dpb_pkg::CMP_W'(dpb_pkg::MAX_DIM);
        else
            height_eff = dpb_pkg::CMP_W'(height_reg);
    end

    // Last-in-row / last-in-frame; a counter past a shrunk dimension counts as last
    assign col_last = (dpb_pkg::CMP_W'(col_reg) + dpb_pkg::CMP_W'(1)) >= width_eff;
    assign row_last = (dpb_pkg::CMP_W'(row_reg) + dpb_pkg::CMP_W'(1)) >= height_eff;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // Classify the pixel into a queue entry
    always_comb
    begin
        q_item.offset_x    = $signed(dpb_pkg::OFS_W'({col_reg, 1'b0}))
                           - $signed(dpb_pkg::OFS_W'(cx_reg));
        q_item.offset_y    = $signed(dpb_pkg::OFS_W'({row_reg, 1'b0}))
                           - $signed(dpb_pkg::OFS_W'(cy_reg));
        q_item.depth_mm    = in_item.depth_mm;
        q_item.depth_valid = in_item.depth_valid;
        q_item.packed_rgb  = {in_item.red, in_item.green, in_item.blue};
        q_item.frame_last  = col_last && row_last;
    end

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + dpb_pkg::CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + dpb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hdl/dpb_queue.sv
`timescale 1ns / 1ps

module dpb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  dpb_pkg::queue_item_t wr_item,
    output logic                 full,
    input  logic                 rd_en,
    output dpb_pkg::queue_item_t rd_item,
    output logic                 empty
);

    dpb_pkg::queue_item_t mem [dpb_pkg::QUEUE_DEPTH];

    logic [dpb_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dpb_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dpb_pkg::QPTR_W:0]   count_reg;
    logic                       do_wr;
    logic                       do_rd;
    logic                       wr_wrap;
    logic                       rd_wrap;

    assign full  = (count_reg == (dpb_pkg::QPTR_W + 1)'(dpb_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    // Pointers wrap at the last entry, whatever the depth
    assign wr_wrap = (wr_ptr_reg == dpb_pkg::QPTR_W'(dpb_pkg::QUEUE_DEPTH - 1));
    assign rd_wrap = (rd_ptr_reg == dpb_pkg::QPTR_W'(dpb_pkg::QUEUE_DEPTH - 1));

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    assign rd_item = mem[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_wrap ? '0 : wr_ptr_reg + dpb_pkg::QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_wrap ? '0 : rd_ptr_reg + dpb_pkg::QPTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (dpb_pkg::QPTR_W + 1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (dpb_pkg::QPTR_W + 1)'(1);
        end
    end

endmodule

// File: hdl/dpb_back.sv
`timescale 1ns / 1ps

module dpb_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  dpb_pkg::queue_item_t       q_item,
    output logic                       q_pop,
    input  logic [dpb_pkg::INVF_W-1:0] inv_focal,
    output logic                       empty,
    input  logic                       pop,
    output dpb_pkg::out_item_t         out_item
);

    typedef struct packed {
        logic                       neg_x;
        logic                       neg_y;
        logic [dpb_pkg::MAG1_W-1:0] mag_x;
        logic [dpb_pkg::MAG1_W-1:0] mag_y;
        logic [dpb_pkg::DEPTH_W-1:0] depth_mm;
        logic                       depth_valid;
        logic [dpb_pkg::RGB_W-1:0]  packed_rgb;
        logic                       frame_last;
    } mul1_t;

    typedef struct packed {
        logic                       neg_x;
        logic                       neg_y;
        logic [dpb_pkg::MAG2_W-1:0] mag_x;
        logic [dpb_pkg::MAG2_W-1:0] mag_y;
        logic [dpb_pkg::DEPTH_W-1:0] depth_mm;
        logic                       depth_valid;
        logic [dpb_pkg::RGB_W-1:0]  packed_rgb;
        logic                       frame_last;
    } mul2_t;

    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      out_valid_reg;
    mul1_t     s1_reg;
    mul1_t     s1_next;
    mul2_t     s2_reg;
    mul2_t     s2_next;
    dpb_pkg::out_item_t out_reg;
    dpb_pkg::out_item_t out_next;

    logic en1;
    logic en2;
    logic en3;
    logic [dpb_pkg::CMP_W-1:0] abs_x;
    logic [dpb_pkg::CMP_W-1:0] abs_y;

    // Round half away from zero, drop the scale, saturate to 32 bits signed
    function automatic logic [dpb_pkg::COORD_W-1:0] round_sat(
        input logic                       neg,
        input logic [dpb_pkg::MAG2_W-1:0] mag
    );
        logic [dpb_pkg::MAG2_W:0] sum;
        logic [63:0]              q;
        logic [dpb_pkg::COORD_W-1:0] res;
        sum = {1'b0, mag} + ((dpb_pkg::MAG2_W + 1)'(1) << (dpb_pkg::ROUND_SHIFT - 1));
        q   = 64'(sum >> dpb_pkg::ROUND_SHIFT);
        if (neg)
        begin
            if (q > 64'h0000_0000_8000_0000)
                res = 32'h8000_0000;
            else
                res = 32'(~q + 64'd1);
        end
        else
        begin
            if (q > 64'h0000_0000_7FFF_FFFF)
                res = 32'h7FFF_FFFF;
            else
                res = q[dpb_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    // Stall chain: a stage moves when its successor is free or moving
    assign en3   = !out_valid_reg || pop;
    assign en2   = !s2_valid_reg || en3;
    assign en1   = !s1_valid_reg || en2;
    assign q_pop = en1 && !q_empty;

    // Stage 1: |offset| * depth
    always_comb
    begin
        abs_x = q_item.offset_x[dpb_pkg::OFS_W-1]
              ? dpb_pkg::CMP_W'(-q_item.offset_x) : dpb_pkg::CMP_W'(q_item.offset_x);
        abs_y = q_item.offset_y[dpb_pkg::OFS_W-1]
              ? dpb_pkg::CMP_W'(-q_item.offset_y) : dpb_pkg::CMP_W'(q_item.offset_y);
        s1_next.neg_x       = q_item.offset_x[dpb_pkg::OFS_W-1];
        s1_next.neg_y       = q_item.offset_y[dpb_pkg::OFS_W-1];
        s1_next.mag_x       = dpb_pkg::MAG1_W'(abs_x) * dpb_pkg::MAG1_W'(q_item.depth_mm);
        s1_next.mag_y       = dpb_pkg::MAG1_W'(abs_y) * dpb_pkg::MAG1_W'(q_item.depth_mm);
        s1_next.depth_mm    = q_item.depth_mm;
        s1_next.depth_valid = q_item.depth_valid;
        s1_next.packed_rgb  = q_item.packed_rgb;
        s1_next.frame_last  = q_item.frame_last;
    end

    // Stage 2: * inv_focal
    always_comb
    begin
        s2_next.neg_x       = s1_reg.neg_x;
        s2_next.neg_y       = s1_reg.neg_y;
        s2_next.mag_x       = dpb_pkg::MAG2_W'(s1_reg.mag_x) * dpb_pkg::MAG2_W'(inv_focal);
        s2_next.mag_y       = dpb_pkg::MAG2_W'(s1_reg.mag_y) * dpb_pkg::MAG2_W'(inv_focal);
        s2_next.depth_mm    = s1_reg.depth_mm;
        s2_next.depth_valid = s1_reg.depth_valid;
        s2_next.packed_rgb  = s1_reg.packed_rgb;
        s2_next.frame_last  = s1_reg.frame_last;
    end

    // Stage 3: rounding, saturation, NaN masking
    always_comb
    begin
        if (s2_reg.depth_valid)
        begin
            out_next.point_x = round_sat(s2_reg.neg_x, s2_reg.mag_x);
            out_next.point_y = round_sat(s2_reg.neg_y, s2_reg.mag_y);
            out_next.point_z = s2_reg.depth_mm;
        end
        else
        begin
            out_next.point_x = '0;
            out_next.point_y = '0;
            out_next.point_z = '0;
        end
        out_next.point_valid = s2_reg.depth_valid;
        out_next.packed_rgb  = s2_reg.packed_rgb;
        out_next.frame_last  = s2_reg.frame_last;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
            out_reg <= out_next;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= !q_empty;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

// File: hdl/depth_pixel_backprojection_core.sv
`timescale 1ns / 1ps

// Depth pixel back-projection: turns a raster-ordered depth/color pixel
// stream into 3-D points (X, Y, Z in mm) plus packed RGB and a frame marker.
//
// Input: drive in_item and raise push; the item is taken on a clock edge
// with push high and full low. Pixels must arrive in raster order; the
// block tracks column and row itself.
// Output: while empty is low, out_item holds the oldest point; it is taken
// on a clock edge with pop high.
// Configuration: cfg_write with cfg_index/cfg_data, only while idle.
//
// Each taken pixel is registered in the queue, then in the stage-1, stage-2
// and output registers. Throughput: one item per cycle unless pop stalls,
// set by the two-stage multiplier pipeline behind a four-entry queue. When
// pop stays low the pipeline fills, then the queue, then full rises; nothing
// is dropped. Reset: counters and queue clear, registers return to 640x480
// defaults; no clearing pass, the block accepts items right after reset.

module depth_pixel_backprojection_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  dpb_pkg::in_item_t                  in_item,
    output logic                               empty,
    input  logic                               pop,
    output dpb_pkg::out_item_t                 out_item,
    input  logic                               cfg_write,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    dpb_pkg::queue_item_t       q_wr_item;
    dpb_pkg::queue_item_t       q_rd_item;
    logic [dpb_pkg::INVF_W-1:0] inv_focal;

    dpb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_wr_item),
        .inv_focal (inv_focal)
    );

    dpb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .empty   (q_empty)
    );

    dpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_rd_item),
        .q_pop     (q_pop),
        .inv_focal (inv_focal),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A taken pixel always leaves an entry in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !q_empty)
        else $error("accepted item missing from queue");

    // A NaN pixel yields a zero point
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.point_valid) |->
        (out_item.point_x == 0 && out_item.point_y == 0 && out_item.point_z == 0))
        else $error("invalid point not zeroed");

    // The back end only drains the queue when it holds something
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");
`endif

endmodule
